/* hdl/rsp_pkg.sv */
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types, codes and character constants for the RESP2 stream parser.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int unsigned MaxDepthDef   = 8;
  localparam int unsigned LengthBitsDef = 32;

  typedef enum logic [2:0] {
    PH_TYPE, PH_TEXT, PH_NUM, PH_SKIP, PH_BULK, PH_BCR, PH_BLF, PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    EV_HEADER = 3'd0,
    EV_TEXT   = 3'd1,
    EV_BULK   = 3'd2,
    EV_DONE   = 3'd3,
    EV_ARRAY  = 3'd4,
    EV_ERROR  = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    KIND_SIMPLE = 3'd0,
    KIND_ERROR  = 3'd1,
    KIND_INT    = 3'd2,
    KIND_BULK   = 3'd3,
    KIND_ARRAY  = 3'd4,
    KIND_NULL   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_TYPE   = 3'd1,
    ERR_BULK   = 3'd2,
    ERR_NUMBER = 3'd3,
    ERR_DEPTH  = 3'd4
  } err_e;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

/* hdl/resp_stream_parser.sv */
// ----------------------------------------------------------------------------
// resp_stream_parser
// Timing: a byte is taken into the input register on acceptance; its event
// is then written into the result register when the output can take it.
// Throughput: one byte per cycle unless out_ready_i holds the result
// register; the parser step is a single pass between the two registers.
// Reset: parser state and handshake registers clear asynchronously; the
// array count stack is not reset and is only read below the current level.
// ----------------------------------------------------------------------------
module resp_stream_parser #(
  parameter int unsigned MAX_DEPTH   = rsp_pkg::MaxDepthDef,
  parameter int unsigned LENGTH_BITS = rsp_pkg::LengthBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               message_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_kind_o,
  output logic [2:0]         value_kind_o,
  output logic [7:0]         byte_echo_o,
  output logic signed [63:0] number_value_o,
  output logic [3:0]         nest_depth_o,
  output logic [3:0]         arrays_closed_o,
  output logic               message_done_o,
  output logic [2:0]         error_code_o
);
  import rsp_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CLW = LW + 1;

  // parser state
  phase_e                  phase_q, phase_d;
  kind_e                   kind_q, kind_d;
  logic [63:0]             acc_q, acc_d;
  logic                    neg_q, neg_d;
  logic                    digit_q, digit_d;
  logic [LENGTH_BITS-1:0]  bulk_q, bulk_d;
  logic [LW-1:0]           level_q, level_d;
  err_e                    err_q, err_d;
  logic [LENGTH_BITS-1:0]  count_q [MAX_DEPTH];

  // input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       s1_adv;

  // result stage
  logic              out_valid_q;
  event_e            ev_q, ev_d;
  kind_e             vk_q;
  logic [7:0]        echo_q;
  logic [63:0]       num_q, num_d;
  logic [3:0]        depth_q, closed_q;
  logic              done_q, done_d;
  err_e              ecode_q, ecode_d;
  logic [CLW-1:0]    closed_d;

  // effective state after an optional message start
  phase_e                 cur_phase;
  kind_e                  cur_kind;
  logic [63:0]            cur_acc;
  logic                   cur_neg;
  logic                   cur_digit;
  logic [LENGTH_BITS-1:0] cur_bulk;
  logic [LW-1:0]          cur_level;
  err_e                   cur_err;

  logic                   fail;
  err_e                   fail_code;
  logic                   cmpl;
  logic [67:0]            acc10;
  logic [67:0]            limit;
  logic                   push_en;
  logic                   dec_en;
  logic [IW-1:0]          dec_idx;
  logic                   found;
  logic [LW-1:0]          new_level;
  logic [LW-1:0]          pops;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    cur_phase = s1_start_q ? PH_TYPE     : phase_q;
    cur_kind  = s1_start_q ? KIND_SIMPLE : kind_q;
    cur_acc   = s1_start_q ? 64'd0       : acc_q;
    cur_neg   = s1_start_q ? 1'b0        : neg_q;
    cur_digit = s1_start_q ? 1'b0        : digit_q;
    cur_bulk  = s1_start_q ? '0          : bulk_q;
    cur_level = s1_start_q ? '0          : level_q;
    cur_err   = s1_start_q ? ERR_NONE    : err_q;

    phase_d  = cur_phase;
    kind_d   = cur_kind;
    acc_d    = cur_acc;
    neg_d    = cur_neg;
    digit_d  = cur_digit;
    bulk_d   = cur_bulk;
    level_d  = cur_level;
    err_d    = cur_err;
    ev_d     = EV_HEADER;
    num_d    = 64'd0;
    closed_d = '0;
    done_d   = 1'b0;
    ecode_d  = ERR_NONE;
    fail     = 1'b0;
    fail_code = ERR_NONE;
    cmpl     = 1'b0;
    push_en  = 1'b0;

    // acc * 10 + digit, checked against the signed magnitude limit
    acc10 = ({4'd0, cur_acc} << 3) + ({4'd0, cur_acc} << 1)
            + {64'd0, 4'(s1_byte_q - CH_ZERO)};
    limit = cur_neg ? {4'd0, 1'b1, 63'd0} : {5'd0, {63{1'b1}}};

    case (cur_phase)
      PH_TYPE: begin
        phase_d = PH_NUM;
        acc_d   = 64'd0;
        neg_d   = 1'b0;
        digit_d = 1'b0;
        case (s1_byte_q)
          CH_PLUS:   begin kind_d = KIND_SIMPLE; phase_d = PH_TEXT; end
          CH_MINUS:  begin kind_d = KIND_ERROR;  phase_d = PH_TEXT; end
          CH_COLON:  kind_d = KIND_INT;
          CH_DOLLAR: kind_d = KIND_BULK;
          CH_STAR:   kind_d = KIND_ARRAY;
          default: begin
            fail      = 1'b1;
            fail_code = ERR_TYPE;
          end
        endcase
      end
      PH_TEXT: begin
        if (s1_byte_q == CH_CR) begin
          phase_d = PH_SKIP;
        end else begin
          ev_d = EV_TEXT;
        end
      end
      PH_NUM: begin
        if (s1_byte_q == CH_CR) begin
          if (!cur_digit) begin
            fail = 1'b1; fail_code = ERR_NUMBER;
          end else if (cur_kind == KIND_BULK && cur_neg && cur_acc > 64'd1) begin
            fail = 1'b1; fail_code = ERR_BULK;
          end else if ((cur_kind == KIND_BULK || cur_kind == KIND_ARRAY) && !cur_neg
                       && (|cur_acc[63:LENGTH_BITS])) begin
            fail = 1'b1; fail_code = ERR_NUMBER;
          end else begin
            acc_d   = cur_neg ? (64'd0 - cur_acc) : cur_acc;
            phase_d = PH_SKIP;
          end
        end else if (s1_byte_q >= CH_ZERO && s1_byte_q <= CH_NINE) begin
          if (acc10 > limit) begin
            fail = 1'b1; fail_code = ERR_NUMBER;
          end else begin
            acc_d   = acc10[63:0];
            digit_d = 1'b1;
          end
        end else if (s1_byte_q == CH_MINUS && !cur_digit && !cur_neg) begin
          neg_d = 1'b1;
        end else begin
          fail = 1'b1; fail_code = ERR_NUMBER;
        end
      end
      PH_SKIP: begin
        if (cur_kind == KIND_SIMPLE || cur_kind == KIND_ERROR) begin
          cmpl = 1'b1;
        end else if (cur_kind == KIND_INT) begin
          cmpl  = 1'b1;
          num_d = cur_acc;
        end else if (cur_kind == KIND_BULK) begin
          num_d = cur_acc;
          if (cur_acc[63]) begin
            kind_d = KIND_NULL;
            cmpl   = 1'b1;
          end else begin
            bulk_d  = cur_acc[LENGTH_BITS-1:0];
            phase_d = (cur_acc[LENGTH_BITS-1:0] == '0) ? PH_BCR : PH_BULK;
          end
        end else begin
          num_d = cur_acc;
          if (cur_acc[63] || cur_acc == 64'd0) begin
            cmpl = 1'b1;
          end else if (cur_level >= LW'(MAX_DEPTH)) begin
            fail = 1'b1; fail_code = ERR_DEPTH;
          end else begin
            push_en = 1'b1;
            level_d = cur_level + LW'(1);
            phase_d = PH_TYPE;
            ev_d    = EV_ARRAY;
          end
        end
      end
      PH_BULK: begin
        ev_d = EV_BULK;
        if (cur_bulk != '0) begin
          bulk_d = cur_bulk - LENGTH_BITS'(1);
        end
        if (cur_bulk <= LENGTH_BITS'(1)) begin
          phase_d = PH_BCR;
        end
      end
      PH_BCR: begin
        if (s1_byte_q == CH_CR) begin
          phase_d = PH_BLF;
        end else begin
          fail = 1'b1; fail_code = ERR_BULK;
        end
      end
      PH_BLF: begin
        if (s1_byte_q == CH_LF) begin
          cmpl = 1'b1;
        end else begin
          fail = 1'b1; fail_code = ERR_BULK;
        end
      end
      default: begin
        ev_d    = EV_ERROR;
        ecode_d = cur_err;
      end
    endcase

    // completion: pop every level whose count is exactly one from the top,
    // the first level below them (if any) just counts down
    found   = 1'b0;
    dec_idx = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (LW'(i) < cur_level && count_q[i] != LENGTH_BITS'(1)) begin
        found   = 1'b1;
        dec_idx = IW'(i);
      end
    end
    new_level = found ? (LW'(dec_idx) + LW'(1)) : '0;
    pops      = cur_level - new_level;
    dec_en    = 1'b0;

    if (cmpl) begin
      dec_en   = found;
      level_d  = new_level;
      phase_d  = PH_TYPE;
      ev_d     = EV_DONE;
      closed_d = CLW'(pops) + ((kind_d == KIND_ARRAY) ? CLW'(1) : CLW'(0));
      done_d   = (new_level == '0);
    end

    if (fail) begin
      phase_d  = PH_ERR;
      err_d    = fail_code;
      ev_d     = EV_ERROR;
      ecode_d  = fail_code;
      num_d    = 64'd0;
      closed_d = '0;
      done_d   = 1'b0;
      push_en  = 1'b0;
      dec_en   = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_start_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_start_q <= message_start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      kind_q  <= KIND_SIMPLE;
      acc_q   <= 64'd0;
      neg_q   <= 1'b0;
      digit_q <= 1'b0;
      bulk_q  <= '0;
      level_q <= '0;
      err_q   <= ERR_NONE;
    end else if (s1_adv) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      digit_q <= digit_d;
      bulk_q  <= bulk_d;
      level_q <= level_d;
      err_q   <= err_d;
    end
  end

  // count stack, one register per level
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (s1_adv && push_en && cur_level[IW-1:0] == IW'(i)) begin
        count_q[i] <= cur_acc[LENGTH_BITS-1:0];
      end else if (s1_adv && dec_en && dec_idx == IW'(i)) begin
        count_q[i] <= count_q[i] - LENGTH_BITS'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ev_q     <= ev_d;
      vk_q     <= kind_d;
      echo_q   <= s1_byte_q;
      num_q    <= num_d;
      depth_q  <= 4'(level_d);
      closed_q <= 4'(closed_d);
      done_q   <= done_d;
      ecode_q  <= ecode_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = ev_q;
  assign value_kind_o    = vk_q;
  assign byte_echo_o     = echo_q;
  assign number_value_o  = num_q;
  assign nest_depth_o    = depth_q;
  assign arrays_closed_o = closed_q;
  assign message_done_o  = done_q;
  assign error_code_o    = ecode_q;

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_kind_o == EV_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match error event");

  a_done_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |-> (nest_depth_o == 4'd0) && (event_kind_o == EV_DONE))
    else $error("message done with open arrays");

  a_closed_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (arrays_closed_o != 4'd0) |-> (event_kind_o == EV_DONE))
    else $error("arrays closed outside a value done event");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(MAX_DEPTH))
    else $error("stack level beyond maximum depth");

endmodule
